// File: sv/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and tables of the Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANG_W      = 16;
  localparam int ANGLE_LIM  = 23040;
  localparam int CW         = 34;   // CORDIC datapath, Q2.30 plus headroom
  localparam int ATAN_N     = 32;
  localparam int ATAN_IDX_W = 5;

  typedef logic signed [CW-1:0] cval_t;

  // One CORDIC datapath: cosine, sine and residual angle for one axis.
  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } rot_t;

  // Three axes moving down the cell chain.
  typedef struct packed {
    rot_t r;
    rot_t p;
    rot_t yw;
  } trio_t;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [CW-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return {2'b00, v};
  endfunction

  // Rounded Q30 product, floor((a*b + 2^29) / 2^30).
  function automatic cval_t mul_q30(input cval_t a, input cval_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return cval_t'(p >>> 30);
  endfunction

endpackage

// File: sv/e2q_prep.sv
// ----------------------------------------------------------------------------
// e2q_prep
// Saturates one angle and converts the half angle to radians Q2.30.
// Constant divide by 46080: split pi/46080 into whole and remainder parts,
// then divide the small remainder term by 1024 * 45, using a reciprocal
// multiply for 45 with one correction step. Three register stages.
// ----------------------------------------------------------------------------
module e2q_prep (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2q_pkg::ANG_W-1:0]  ang,
  output logic signed [e2q_pkg::CW-1:0]     z_r
);
  import e2q_pkg::*;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint DIV    = 46080;
  localparam longint ODD    = DIV / 1024;
  // mag * pi / 46080 = mag * PI_INT + mag * PI_FRAC / 46080
  localparam logic [30:0] PI_INT   = 31'(PI_Q30 / DIV);
  localparam logic [28:0] PI_FRAC  = 29'(PI_Q30 % DIV);
  localparam logic [28:0] HALF_RND = 29'(DIV / 2);
  // reciprocal of 45 scaled 2^24, rounded down
  localparam logic [18:0] RECIP    = 19'((64'sd1 <<< 24) / ODD);

  logic [14:0] mag;
  logic        neg_r;
  logic        neg2_r;
  logic [30:0] base_r;
  logic [30:0] base2_r;
  logic [28:0] num_r;
  logic [18:0] nq_r;
  logic [37:0] qprod;
  logic [13:0] q0;
  logic [13:0] q0_r;
  logic [13:0] q;
  logic [19:0] rem;
  logic [31:0] zmag;
  logic signed [CW-1:0] z_nxt;

  always_comb begin
    if (ang > $signed(16'(ANGLE_LIM)))       mag = 15'(ANGLE_LIM);
    else if (ang < -$signed(16'(ANGLE_LIM))) mag = 15'(ANGLE_LIM);
    else if (ang < 0)                        mag = 15'(-ang);
    else                                     mag = 15'(ang);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r   <= ang < 0;
      base_r  <= 31'(mag) * PI_INT;
      num_r   <= 29'(mag) * PI_FRAC + HALF_RND;
      neg2_r  <= neg_r;
      base2_r <= base_r;
      nq_r    <= num_r[28:10];
      q0_r    <= q0;
      z_r     <= z_nxt;
    end
  end

  // Quotient estimate by 45, low by at most one.
  always_comb begin
    qprod = 38'(num_r[28:10]) * 38'(RECIP);
    q0    = 14'(qprod >> 24);
  end

  always_comb begin
    rem   = 20'(nq_r) - 20'(q0_r) * 20'(ODD);
    q     = (rem >= 20'(ODD)) ? q0_r + 14'd1 : q0_r;
    zmag  = 32'(base2_r) + 32'(q);
    z_nxt = neg2_r ? -CW'($signed({1'b0, zmag})) : CW'($signed({1'b0, zmag}));
  end

endmodule

// File: sv/e2q_cell.sv
// ----------------------------------------------------------------------------
// e2q_cell
// One CORDIC rotation step for all three axes, registered.
// ----------------------------------------------------------------------------
module e2q_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  e2q_pkg::trio_t d,
  output e2q_pkg::trio_t q_r
);
  import e2q_pkg::*;

  localparam cval_t ATN = atan_q30(ATAN_IDX_W'(STAGE));

  function automatic rot_t step(input rot_t a);
    rot_t o;
    cval_t dx, dy;
    dx = a.y >>> STAGE;
    dy = a.x >>> STAGE;
    if (!a.z[CW-1]) begin
      o.x = a.x - dx; o.y = a.y + dy; o.z = a.z - ATN;
    end else begin
      o.x = a.x + dx; o.y = a.y - dy; o.z = a.z + ATN;
    end
    return o;
  endfunction

  trio_t q_nxt;

  always_comb begin
    q_nxt.r  = step(d.r);
    q_nxt.p  = step(d.p);
    q_nxt.yw = step(d.yw);
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

endmodule

// File: sv/e2q_combine.sv
// ----------------------------------------------------------------------------
// e2q_combine
// Forms the quaternion from the half-angle cosines and sines, rounds and
// saturates each component.
// ----------------------------------------------------------------------------
module e2q_combine #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  e2q_pkg::trio_t               d,
  output logic signed [QUAT_WIDTH-1:0] w_r,
  output logic signed [QUAT_WIDTH-1:0] x_r,
  output logic signed [QUAT_WIDTH-1:0] y_r,
  output logic signed [QUAT_WIDTH-1:0] z_r
);
  import e2q_pkg::*;

  localparam int FB = QUAT_WIDTH - 1;

  cval_t crcp_r, srsp_r, srcp_r, crsp_r, cy_r, sy_r;
  cval_t t0_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r;
  cval_t sw_r, sx_r, sy2_r, sz_r;

  function automatic logic signed [QUAT_WIDTH-1:0] to_out(input cval_t v);
    logic signed [CW+2:0] r;
    logic signed [CW+2:0] lim;
    lim = (CW+3)'((64'sd1 <<< FB) - 1);
    if (FB <= 30) begin
      if (FB == 30) r = (CW+3)'(v);
      else r = ((CW+3)'(v) + ((CW+3)'(1) <<< ((30 - FB) > 0 ? 29 - FB : 0))) >>> (30 - FB);
    end else begin
      r = (CW+3)'(v) <<< (FB > 30 ? FB - 30 : 0);
    end
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return QUAT_WIDTH'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      crcp_r <= mul_q30(d.r.x, d.p.x);
      srsp_r <= mul_q30(d.r.y, d.p.y);
      srcp_r <= mul_q30(d.r.y, d.p.x);
      crsp_r <= mul_q30(d.r.x, d.p.y);
      cy_r   <= d.yw.x;
      sy_r   <= d.yw.y;
      t0_r <= mul_q30(crcp_r, cy_r);
      t1_r <= mul_q30(srsp_r, sy_r);
      t2_r <= mul_q30(srcp_r, cy_r);
      t3_r <= mul_q30(crsp_r, sy_r);
      t4_r <= mul_q30(crsp_r, cy_r);
      t5_r <= mul_q30(srcp_r, sy_r);
      t6_r <= mul_q30(crcp_r, sy_r);
      t7_r <= mul_q30(srsp_r, cy_r);
      sw_r  <= t0_r + t1_r;
      sx_r  <= t2_r - t3_r;
      sy2_r <= t4_r + t5_r;
      sz_r  <= t6_r - t7_r;
      w_r <= to_out(sw_r);
      x_r <= to_out(sx_r);
      y_r <= to_out(sy2_r);
      z_r <= to_out(sz_r);
    end
  end

endmodule

// File: sv/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll/pitch/yaw in 1/128 degree to a ZYX unit quaternion, Q1.(QUAT_WIDTH-1).
// ----------------------------------------------------------------------------
// Path: the prep, rotation cell, combine and output registers lie between input transfer and result.
// Throughput: one transfer per cycle; the whole pipe advances when the
// output register is empty or being taken, so in_stall follows out_stall.
// Reset: rst_n (synchronous) clears the stage valid bits only; data
// registers keep whatever they hold.
module euler_to_quaternion #(
  parameter int ROTATION_STAGES = 16,
  parameter int QUAT_WIDTH      = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           in_roll_angle,
  input  logic signed [15:0]           in_pitch_angle,
  input  logic signed [15:0]           in_yaw_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [QUAT_WIDTH-1:0] out_quat_w,
  output logic signed [QUAT_WIDTH-1:0] out_quat_x,
  output logic signed [QUAT_WIDTH-1:0] out_quat_y,
  output logic signed [QUAT_WIDTH-1:0] out_quat_z
);
  import e2q_pkg::*;

  // prep: 3 stages, cells: ROTATION_STAGES, combine: 4 stages, output: 1
  localparam int DEPTH = 3 + ROTATION_STAGES + 4;

  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             adv;
  cval_t            zr, zp, zy;
  trio_t            chain [ROTATION_STAGES+1];
  logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;
  logic             ovld_r, ovld_nxt;

  // Advance the whole pipe whenever the output stage can take a new item.
  assign adv      = !ovld_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    vld_nxt  = vld_r;
    ovld_nxt = ovld_r;
    if (adv) begin
      vld_nxt  = {vld_r[DEPTH-2:0], in_valid};
      ovld_nxt = vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  e2q_prep u_prep_r (.clk, .en(adv), .ang(in_roll_angle),  .z_r(zr));
  e2q_prep u_prep_p (.clk, .en(adv), .ang(in_pitch_angle), .z_r(zp));
  e2q_prep u_prep_y (.clk, .en(adv), .ang(in_yaw_angle),   .z_r(zy));

  always_comb begin
    chain[0].r  = '{x: CORDIC_GAIN, y: '0, z: zr};
    chain[0].p  = '{x: CORDIC_GAIN, y: '0, z: zp};
    chain[0].yw = '{x: CORDIC_GAIN, y: '0, z: zy};
  end

  // Chain of rotation cells, one micro-rotation each.
  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
    e2q_cell #(.STAGE(g)) u_cell (
      .clk, .en(adv), .d(chain[g]), .q_r(chain[g+1])
    );
  end

  e2q_combine #(.QUAT_WIDTH(QUAT_WIDTH)) u_comb (
    .clk, .en(adv), .d(chain[ROTATION_STAGES]),
    .w_r(qw), .x_r(qx), .y_r(qy), .z_r(qz)
  );

  // Output register: combine results line up with the last valid bit, this register with ovld_r.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_quat_w <= qw;
      out_quat_x <= qx;
      out_quat_y <= qy;
      out_quat_z <= qz;
    end
  end

  assign out_valid = ovld_r;

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && out_stall |=> ovld_r && $stable(out_quat_w))
    else $error("result changed while stalled");

  // Input is stalled exactly when a result waits under stall.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (ovld_r && out_stall))
    else $error("input stall mismatch");

  // The w output never reaches the negative full scale.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> out_quat_w != {1'b1, {(QUAT_WIDTH-1){1'b0}}})
    else $error("saturation escaped");

endmodule

// File: tb/tb_euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion
// Drives roll/pitch/yaw triples into the Euler-to-quaternion pipeline and
// compares every quaternion against a bit-exact fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------
module tb_euler_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES    = 16;
  localparam int QW        = 16;
  localparam int LATENCY   = STAGES + 8;
  localparam int IDLE_LIMIT = 5000;
  localparam longint PI_Q30_C = 64'sd3373259426;
  localparam longint HALF_DIV = 64'sd46080;
  localparam longint GAIN_C   = 64'sd652032874;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_roll_angle = '0;
  logic signed [15:0] in_pitch_angle = '0;
  logic signed [15:0] in_yaw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [QW-1:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;

  quat_t expected_quats[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stall_enable = 1'b1;

  euler_to_quaternion #(.ROTATION_STAGES(STAGES), .QUAT_WIDTH(QW)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_roll_angle(in_roll_angle), .in_pitch_angle(in_pitch_angle),
    .in_yaw_angle(in_yaw_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Arctangent table, atan(2^-i) scaled 2^30; truncated, but rounded for i = 27 to 30.
  function automatic longint arctan_q30(input int i);
    case (i)
      0: return 64'h3243F6A8;   1: return 64'h1DAC6705;
      2: return 64'h0FADBAFC;   3: return 64'h07F56EA6;
      4: return 64'h03FEAB76;   5: return 64'h01FFD55B;
      6: return 64'h00FFFAAA;   7: return 64'h007FFF55;
      8: return 64'h003FFFEA;   9: return 64'h001FFFFD;
      10: return 64'h000FFFFF;  11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;  13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;  15: return 64'h00007FFF;
      16: return 64'h00003FFF;  17: return 64'h00001FFF;
      18: return 64'h00000FFF;  19: return 64'h000007FF;
      20: return 64'h000003FF;  21: return 64'h000001FF;
      22: return 64'h000000FF;  23: return 64'h0000007F;
      24: return 64'h0000003F;  25: return 64'h0000001F;
      26: return 64'h0000000F;  27: return 64'h00000008;
      28: return 64'h00000004;  29: return 64'h00000002;
      30: return 64'h00000001;  default: return 64'h0;
    endcase
  endfunction

  // >>> on a signed longint is an arithmetic (floor) shift.
  function automatic longint round_prod(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Clamp to +/-180 deg, then rotate from the gain constant toward the half angle.
  task automatic half_angle_trig(input logic signed [15:0] raw,
                                 output longint c, output longint s);
    longint a, mag, zr, xr, yr, dx, dy;
    a = raw;
    if (a > 23040) a = 23040;
    if (a < -23040) a = -23040;
    mag = (a < 0) ? -a : a;
    zr = (mag * PI_Q30_C + HALF_DIV / 2) / HALF_DIV;
    if (a < 0) zr = -zr;
    xr = GAIN_C;
    yr = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (zr >= 0) begin
        xr -= dx; yr += dy; zr -= arctan_q30(i);
      end else begin
        xr += dx; yr -= dy; zr += arctan_q30(i);
      end
    end
    c = xr;
    s = yr;
  endtask

  // Round Q30 to Q1.(QW-1) and saturate symmetrically.
  function automatic logic signed [QW-1:0] to_quat_comp(input longint v);
    longint r, lim;
    int sh;
    lim = (64'sd1 <<< (QW - 1)) - 1;
    sh = 30 - (QW - 1);
    if (sh > 0) r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    else if (sh == 0) r = v;
    else r = v * (64'sd1 <<< (-sh));
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[QW-1:0];
  endfunction

  task automatic predict_quaternion(input logic signed [15:0] roll,
                                    input logic signed [15:0] pitch,
                                    input logic signed [15:0] yaw,
                                    output quat_t q);
    longint cr, sr, cp, sp, cy, sy, crcp, srsp, srcp, crsp;
    half_angle_trig(roll, cr, sr);
    half_angle_trig(pitch, cp, sp);
    half_angle_trig(yaw, cy, sy);
    crcp = round_prod(cr, cp);
    srsp = round_prod(sr, sp);
    srcp = round_prod(sr, cp);
    crsp = round_prod(cr, sp);
    q.w = to_quat_comp(round_prod(crcp, cy) + round_prod(srsp, sy));
    q.x = to_quat_comp(round_prod(srcp, cy) - round_prod(crsp, sy));
    q.y = to_quat_comp(round_prod(crsp, cy) + round_prod(srcp, sy));
    q.z = to_quat_comp(round_prod(crcp, sy) - round_prod(srsp, cy));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Send one angle triple; hold it until the transfer happens.
  task automatic send_angles(input logic signed [15:0] roll,
                             input logic signed [15:0] pitch,
                             input logic signed [15:0] yaw, input bit gaps);
    quat_t q;
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_roll_angle <= roll;
    in_pitch_angle <= pitch;
    in_yaw_angle <= yaw;
    in_valid <= 1'b1;
    predict_quaternion(roll, pitch, yaw, q);
    do @(posedge clk); while (in_stall);
    expected_quats = {expected_quats, q};
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // Random angle, mostly in range, some beyond +/-180 deg or at full scale.
  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(23041, 32767));
      2: return -16'($urandom_range(23041, 32768));
      default: return 16'($signed($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [15:0] vals[8];
    vals = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd32767, -16'sd32768,
             16'sd23041, -16'sd23041, 16'sd11520};
    for (int i = 0; i < 8; i++) send_angles(vals[i], 16'sd0, 16'sd0, 1'b0);
    for (int i = 0; i < 8; i++) send_angles(16'sd0, vals[i], vals[7 - i], 1'b0);
    send_angles(16'sd23040, 16'sd23040, 16'sd23040, 1'b0);
    send_angles(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_angles(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_angles(16'sd1, -16'sd1, 16'sd128, 1'b0);
    release_input();
  endtask

  task automatic test_random_stream(input int n, input bit gaps);
    for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle(), gaps);
    release_input();
  endtask

  // Send a burst, hold the sender until every outstanding quaternion has come back, then send a burst with gaps.
  task automatic test_drain_pause();
    test_random_stream(30, 1'b0);
    while (expected_quats.size() != 0) @(negedge clk);
    test_random_stream(30, 1'b1);
  endtask

  // Receiver stall: random gaps, with stretches of none.
  always @(negedge clk) begin
    if (!stall_enable) out_stall <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) != 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 5) == 0);
  end

  // Check each transfer on the result channel against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected result", out_quat_w, 0);
      end else begin
        quat_t e;
        e = expected_quats.pop_front();
        if (out_quat_w !== e.w) report_mismatch("quat_w", out_quat_w, e.w);
        if (out_quat_x !== e.x) report_mismatch("quat_x", out_quat_x, e.x);
        if (out_quat_y !== e.y) report_mismatch("quat_y", out_quat_y, e.y);
        if (out_quat_z !== e.z) report_mismatch("quat_z", out_quat_z, e.z);
      end
    end
  end

  // Watchdog: advance the idle count on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_euler_to_quaternion: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    stall_enable = 1'b0;
    test_random_stream(200, 1'b0);
    stall_enable = 1'b1;
    test_drain_pause();
    test_random_stream(740, 1'b1);
    while (expected_quats.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("tb_euler_to_quaternion: PASS");
    end else begin
      $display("tb_euler_to_quaternion: FAIL");
    end
    $finish;
  end
endmodule
